// ===== rtl/gdl90_frame_unstuff_crc_check_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef GDL90_FRAME_UNSTUFF_CRC_CHECK_MACROS_SVH
`define GDL90_FRAME_UNSTUFF_CRC_CHECK_MACROS_SVH
`ifndef SYNTHESIS
`define GDLFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gdlfc assertion failed");
`define GDLFC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define GDLFC_ASSERT(lbl, prop)
`define GDLFC_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// ===== rtl/gdlfc_pkg.sv =====
`default_nettype none
package gdlfc_pkg;

  localparam logic [7:0]  EscByte = 8'h7D;
  localparam logic [7:0]  EscXor  = 8'h20;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [1:0]  MinLen  = 2'd3;

  // result queue, depth must be a power of two
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KIND_ID  = 2'd0,
    KIND_PAY = 2'd1,
    KIND_END = 2'd2
  } gdlfc_kind_e;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_CRC   = 2'd1,
    ST_ESC   = 2'd2,
    ST_SHORT = 2'd3
  } gdlfc_status_e;

  typedef struct packed {
    gdlfc_kind_e   kind;
    logic [7:0]    data;
    gdlfc_status_e status;
    logic          last;
  } gdlfc_res_t;

  typedef struct packed {
    logic [1:0] num;
    gdlfc_res_t res0;
    gdlfc_res_t res1;
  } gdlfc_push_t;

  // crc-16 table entry for polynomial 0x1021
  function automatic logic [15:0] crc_tab(input logic [7:0] idx);
    logic [15:0] v;
    v = {idx, 8'h00};
    for (int k = 0; k < 8; k++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ CrcPoly) : {v[14:0], 1'b0};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gdlfc_in_if.sv =====
`default_nettype none
interface gdlfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       frame_last;

  modport source(output valid, output raw_byte, output frame_last, input ready);
  modport sink(input valid, input raw_byte, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/gdlfc_out_if.sv =====
`default_nettype none
interface gdlfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] frame_status;
  logic       run_last;

  modport source(output valid, output out_kind, output out_byte, output frame_status,
                 output run_last, input ready);
  modport sink(input valid, input out_kind, input out_byte, input frame_status,
               input run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/gdlfc_core.sv =====
`default_nettype none
`include "gdl90_frame_unstuff_crc_check_macros.svh"
module gdlfc_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  gdlfc_in_if.sink            in_i,
  output gdlfc_pkg::gdlfc_push_t push_o,
  input  wire logic           room_i
);
  import gdlfc_pkg::*;

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] raw_q;
  logic       last_q;
  logic       adv;
  logic       in_xfer;

  // frame state
  logic        esc_q, esc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held_q [2];
  logic [7:0]  held_d [2];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [1:0]  raw_cnt_q, raw_cnt_d;
  logic [1:0]  dec_cnt_q, dec_cnt_d;
  logic        id_rel_q, id_rel_d;

  logic          have_dec;
  logic [7:0]    dec;
  logic          release_b;
  logic [1:0]    raw_cnt_n, dec_cnt_n;
  logic          esc_n;
  logic [15:0]   crc_n;
  logic [7:0]    held0_n, held1_n;
  gdlfc_status_e status;
  gdlfc_res_t    byte_res, end_res;

  assign adv       = in_vld_q & room_i;
  assign in_i.ready = ~in_vld_q | room_i;
  assign in_xfer   = in_i.valid & in_i.ready;
  assign in_vld_d  = in_xfer | (in_vld_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      raw_q  <= in_i.raw_byte;
      last_q <= in_i.frame_last;
    end
  end

  always_comb begin
    raw_cnt_n = (raw_cnt_q < MinLen) ? raw_cnt_q + 2'd1 : raw_cnt_q;
    // a 0x7d always (re)arms the escape and yields nothing
    have_dec  = (raw_q != EscByte);
    esc_n     = ~have_dec;
    dec       = esc_q ? (raw_q ^ EscXor) : raw_q;
    dec_cnt_n = (have_dec && dec_cnt_q < MinLen) ? dec_cnt_q + 2'd1 : dec_cnt_q;
    release_b = have_dec && (held_cnt_q == 2'd2);

    crc_n    = crc_q;
    held0_n  = held_q[0];
    held1_n  = held_q[1];
    held_cnt_d = held_cnt_q;
    if (release_b) begin
      crc_n   = crc_tab(crc_q[15:8]) ^ {crc_q[7:0], 8'h00} ^ {8'h00, held_q[0]};
      held0_n = held_q[1];
      held1_n = dec;
    end else if (have_dec) begin
      if (held_cnt_q[0]) begin
        held1_n = dec;
      end else begin
        held0_n = dec;
      end
      held_cnt_d = held_cnt_q + 2'd1;
    end

    if (raw_cnt_n < MinLen) begin
      status = ST_SHORT;
    end else if (esc_n) begin
      status = ST_ESC;
    end else if (dec_cnt_n < MinLen) begin
      status = ST_SHORT;
    end else if ({held1_n, held0_n} == crc_n) begin
      status = ST_GOOD;
    end else begin
      status = ST_CRC;
    end

    held_d[0] = held0_n;
    held_d[1] = held1_n;
    esc_d     = esc_n;
    crc_d     = crc_n;
    raw_cnt_d = raw_cnt_n;
    dec_cnt_d = dec_cnt_n;
    id_rel_d  = id_rel_q | release_b;
    if (last_q) begin
      esc_d      = 1'b0;
      crc_d      = '0;
      held_cnt_d = '0;
      raw_cnt_d  = '0;
      dec_cnt_d  = '0;
      id_rel_d   = 1'b0;
    end

    byte_res.kind   = id_rel_q ? KIND_PAY : KIND_ID;
    byte_res.data   = held_q[0];
    byte_res.status = ST_GOOD;
    byte_res.last   = ~last_q;
    end_res.kind    = KIND_END;
    end_res.data    = '0;
    end_res.status  = status;
    end_res.last    = 1'b1;

    push_o.num  = adv ? ({1'b0, release_b} + {1'b0, last_q}) : 2'd0;
    push_o.res0 = release_b ? byte_res : end_res;
    push_o.res1 = end_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      crc_q      <= '0;
      held_cnt_q <= '0;
      raw_cnt_q  <= '0;
      dec_cnt_q  <= '0;
      id_rel_q   <= 1'b0;
    end else if (adv) begin
      esc_q      <= esc_d;
      crc_q      <= crc_d;
      held_cnt_q <= held_cnt_d;
      raw_cnt_q  <= raw_cnt_d;
      dec_cnt_q  <= dec_cnt_d;
      id_rel_q   <= id_rel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      held_q[0] <= held_d[0];
      held_q[1] <= held_d[1];
    end
  end

  `GDLFC_ASSERT(a_frame_end_clears, adv && last_q |=> !esc_q && held_cnt_q == 2'd0 && raw_cnt_q == 2'd0 && !id_rel_q)
  `GDLFC_ASSERT(a_id_needs_full_hold, id_rel_q |-> held_cnt_q == 2'd2)
  `GDLFC_ASSERT_MSG(a_hold_le_decoded, held_cnt_q <= dec_cnt_q, "held count ahead of decoded count")
endmodule
`default_nettype wire

// ===== rtl/gdlfc_fifo.sv =====
`default_nettype none
`include "gdl90_frame_unstuff_crc_check_macros.svh"
module gdlfc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gdlfc_pkg::gdlfc_push_t push_i,
  output logic                   room_o,
  gdlfc_out_if.source            out_o
);
  import gdlfc_pkg::*;

  gdlfc_res_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  pop;
  gdlfc_res_t            head;

  // room for two results so any item can be taken
  assign room_o = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign pop    = out_o.valid & out_o.ready;
  assign wr_d   = wr_q + FifoPtrW'(push_i.num);
  assign rd_d   = rd_q + FifoPtrW'(pop);
  assign cnt_d  = cnt_q + FifoCntW'(push_i.num) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + FifoPtrW'(1)] <= push_i.res1;
    end
  end

  assign head               = mem_q[rd_q];
  assign out_o.valid        = cnt_q != '0;
  assign out_o.out_kind     = head.kind;
  assign out_o.out_byte     = head.data;
  assign out_o.frame_status = head.status;
  assign out_o.run_last     = head.last;

  `GDLFC_ASSERT(a_cnt_bound, cnt_q <= FifoCntW'(FifoDepth))
  `GDLFC_ASSERT(a_ptr_match_cnt, cnt_q[FifoPtrW-1:0] == FifoPtrW'(wr_q - rd_q))
  `GDLFC_ASSERT_MSG(a_no_overflow, push_i.num != 2'd0 |-> room_o, "result queue overflow")
endmodule
`default_nettype wire

// ===== rtl/gdl90_frame_unstuff_crc_check.sv =====
// gdl90 frame un-stuffing and crc-16 check
//
// in_i carries raw frame bytes (flags stripped), one per transfer, with
// frame_last on the final byte. out_o carries results: the message id byte,
// payload bytes, and one frame-end status after the last byte of a frame.
// the two newest decoded bytes are held as the checksum, so a byte leaves
// only once two newer decoded bytes have arrived.
// a byte is taken into the input register, decoded from there into a
// 4-entry result queue once the queue has room, and can then be transferred.
// throughput: one byte per cycle while the queue has room; the frame's last
// byte can produce two results, which the output side drains one per cycle.
// the input register and result queue decouple the sides: input is taken
// while earlier results wait, until the queue lacks room for two results.
// a stalled receiver thus backs up into in_i.ready once the queue fills.
// reset (rst_ni low, asynchronous) empties the queue and clears the
// escape, crc and counter state; no clearing pass is needed.
`default_nettype none
module gdl90_frame_unstuff_crc_check (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gdlfc_in_if.sink    in_i,
  gdlfc_out_if.source out_o
);
  import gdlfc_pkg::*;

  gdlfc_push_t push;
  logic        room;

  gdlfc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .room_i (room)
  );

  gdlfc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gdlfc_pkg::*;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam int unsigned WdLimit = 5000;
  localparam int unsigned ItemsPerPhase = 240;
  localparam int unsigned NumDirected = 22;

  typedef struct packed {
    logic [7:0]    raw;
    logic          last;
    logic          typed;
    gdlfc_status_e status;
  } dir_row_t;

  // hand-built frames: length limits, escapes, good and bad checksums
  dir_row_t dir_tab [0:NumDirected-1] = '{
    '{8'hFF, 1'b1, 1'b1, ST_SHORT},
    '{8'h00, 1'b0, 1'b0, ST_GOOD},
    '{8'hFF, 1'b1, 1'b1, ST_SHORT},
    '{8'h7D, 1'b0, 1'b0, ST_GOOD},
    '{8'h7D, 1'b0, 1'b0, ST_GOOD},
    '{8'h7D, 1'b1, 1'b1, ST_ESC},
    '{8'h7D, 1'b0, 1'b0, ST_GOOD},
    '{8'h5E, 1'b0, 1'b0, ST_GOOD},
    '{8'h7D, 1'b0, 1'b0, ST_GOOD},
    '{8'h5D, 1'b1, 1'b1, ST_SHORT},
    '{8'h00, 1'b0, 1'b0, ST_GOOD},
    '{8'h00, 1'b0, 1'b0, ST_GOOD},
    '{8'h00, 1'b1, 1'b1, ST_GOOD},
    '{8'hFF, 1'b0, 1'b0, ST_GOOD},
    '{8'h00, 1'b0, 1'b0, ST_GOOD},
    '{8'h00, 1'b1, 1'b1, ST_CRC},
    '{8'h7D, 1'b0, 1'b0, ST_GOOD},
    '{8'h7D, 1'b0, 1'b0, ST_GOOD},
    '{8'h5D, 1'b0, 1'b0, ST_GOOD},
    '{8'h7D, 1'b0, 1'b0, ST_GOOD},
    '{8'h5D, 1'b0, 1'b0, ST_GOOD},
    '{8'h00, 1'b1, 1'b1, ST_GOOD}
  };

  int phase_idle  [0:3] = '{0, 82, 0, 13};
  int phase_stall [0:3] = '{0, 0, 82, 13};

  logic clk;
  logic rst_n;

  gdlfc_in_if  in_if();
  gdlfc_out_if out_if();

  gdl90_frame_unstuff_crc_check dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // frame decoder shadow state
  logic        esc_pend;
  logic [15:0] crc_acc;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [1:0]  held_cnt;
  logic [1:0]  raw_cnt;
  logic [1:0]  dec_cnt;
  logic        id_seen;

  gdlfc_res_t pending_res[$];
  gdlfc_res_t want;

  int src_idle_pct;
  int snk_stall_pct;
  int items_sent;
  int err_cnt;
  int quiet_cycles;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one crc byte step: reduce {crc, byte} over the top eight bits
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [23:0] v;
    logic [23:0] p;
    v = {c, b};
    p = {7'd0, 1'b1, CrcPoly};
    for (int k = 23; k >= 16; k--) begin
      if (v[k]) v = v ^ (p << (k - 16));
    end
    return v[15:0];
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return EscByte;
      1: return FlagByte;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic clear_frame();
    esc_pend = 1'b0;
    crc_acc  = '0;
    held0    = '0;
    held1    = '0;
    held_cnt = '0;
    raw_cnt  = '0;
    dec_cnt  = '0;
    id_seen  = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] raw, input logic last,
                              input logic typed, input gdlfc_status_e typed_st);
    gdlfc_res_t    res [0:1];
    int            n;
    logic          have;
    logic [7:0]    dec;
    gdlfc_status_e st;
    n    = 0;
    have = 1'b0;
    dec  = '0;
    if (raw_cnt < MinLen) raw_cnt++;
    if (raw == EscByte) begin
      esc_pend = 1'b1;
    end else begin
      dec      = esc_pend ? (raw ^ EscXor) : raw;
      esc_pend = 1'b0;
      have     = 1'b1;
    end
    if (have) begin
      if (dec_cnt < MinLen) dec_cnt++;
      if (held_cnt == 2'd2) begin
        crc_acc = crc_next(crc_acc, held0);
        res[n] = '{kind: id_seen ? KIND_PAY : KIND_ID, data: held0, status: ST_GOOD,
                   last: 1'b0};
        n++;
        id_seen = 1'b1;
        held0   = held1;
        held1   = dec;
      end else begin
        if (held_cnt == 2'd0) held0 = dec;
        else held1 = dec;
        held_cnt++;
      end
    end
    if (last) begin
      if (raw_cnt < MinLen) st = ST_SHORT;
      else if (esc_pend) st = ST_ESC;
      else if (dec_cnt < MinLen) st = ST_SHORT;
      else st = ({held1, held0} == crc_acc) ? ST_GOOD : ST_CRC;
      if (typed) st = typed_st;
      res[n] = '{kind: KIND_END, data: 8'h00, status: st, last: 1'b0};
      n++;
      clear_frame();
    end
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      pending_res.push_back(res[i]);
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic put_byte(input logic [7:0] b, input logic l, input logic typed = 1'b0,
                          input gdlfc_status_e st = ST_GOOD);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.raw_byte   <= b;
    in_if.frame_last <= l;
    do @(posedge clk); while (!in_if.ready);
    predict_byte(b, l, typed, st);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic random_frame();
    logic [7:0]  msg[$];
    logic [7:0]  raw_q[$];
    logic [15:0] crc;
    int          len;
    int          sel;
    int          pos;
    sel = $urandom_range(99);
    if (sel < 85) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      crc = '0;
      repeat (len) msg.push_back(pick_byte());
      foreach (msg[i]) crc = crc_next(crc, msg[i]);
      msg.push_back(crc[7:0]);
      msg.push_back(crc[15:8]);
      foreach (msg[i]) begin
        // escape the reserved bytes, now and then an ordinary one too;
        // 0x5d would stuff into another escape marker
        if (msg[i] == EscByte || msg[i] == FlagByte ||
            (msg[i] != 8'h5D && $urandom_range(19) == 0)) begin
          raw_q.push_back(EscByte);
          if ($urandom_range(7) == 0) raw_q.push_back(EscByte);
          raw_q.push_back(msg[i] ^ EscXor);
        end else begin
          raw_q.push_back(msg[i]);
        end
      end
      // corrupt one bit of a well-formed frame
      if (sel >= 70) begin
        pos = $urandom_range(raw_q.size() - 1);
        raw_q[pos] = raw_q[pos] ^ (8'h01 << $urandom_range(7));
      end
    end else begin
      len = $urandom_range(1, 4);
      repeat (len) raw_q.push_back(pick_byte());
      if (sel >= 95) raw_q.push_back(EscByte);
    end
    foreach (raw_q[i]) put_byte(raw_q[i], i == raw_q.size() - 1);
  endtask

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_res.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: kind %0d byte %02h status %0d last %0b",
                   out_if.out_kind, out_if.out_byte, out_if.frame_status, out_if.run_last);
      end else begin
        want = pending_res.pop_front();
        if (out_if.out_kind !== want.kind || out_if.out_byte !== want.data ||
            out_if.frame_status !== want.status || out_if.run_last !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected kind %0d byte %02h status %0d last %0b, got %0d %02h %0d %0b",
                     want.kind, want.data, want.status, want.last, out_if.out_kind,
                     out_if.out_byte, out_if.frame_status, out_if.run_last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WdLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int start;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.raw_byte   = '0;
    in_if.frame_last = 1'b0;
    out_if.ready     = 1'b0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    items_sent       = 0;
    err_cnt          = 0;
    quiet_cycles     = 0;
    clear_frame();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      put_byte(dir_tab[i].raw, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].status);
    end

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = phase_idle[ph];
      snk_stall_pct = phase_stall[ph];
      start = items_sent;
      while (items_sent - start < ItemsPerPhase) random_frame();
    end
    in_if.valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/gdlfc_pkg.sv
rtl/gdlfc_in_if.sv
rtl/gdlfc_out_if.sv
rtl/gdlfc_core.sv
rtl/gdlfc_fifo.sv
rtl/gdl90_frame_unstuff_crc_check.sv
verif/testbench.sv
